// ----- rtl/pec_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pec_pkg: shared types and constants of the percent escape codec
// item layouts, decoder state record and character codes
// ----------------------------------------------------------------------------
package pec_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    typedef struct packed {
        logic       quote_mode;
        logic       just_toggled;
        logic [1:0] escape_phase;
        logic [3:0] hex_partial;
        logic       hex_stopped;
        logic       string_ended;
    } dec_state_t;

    // escape phases
    localparam logic [1:0] PHASE_NONE  = 2'd0;
    localparam logic [1:0] PHASE_FIRST = 2'd1;
    localparam logic [1:0] PHASE_SECOND = 2'd2;

    // direction register codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_TILDE   = 8'h7E;

    // upper-case hex digit for a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        begin
            if (nib < 4'd10) begin
                r = 8'h30 + {4'h0, nib};
            end else begin
                r = 8'h37 + {4'h0, nib};
            end
            return r;
        end
    endfunction

    // {is_hex, value} of a character, either case
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        begin
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b1, c[3:0]};
            end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
                r = {1'b1, c[3:0] + 4'd9};
            end else begin
                r = 5'd0;
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/pec_codec.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pec_codec: one-item escape encode / decode step
// gives up to three characters for one item and the next decoder state
// ----------------------------------------------------------------------------
module pec_codec (
    input  wire logic                 direction,
    input  wire pec_pkg::in_item_t    item,
    input  wire pec_pkg::dec_state_t  st,
    output pec_pkg::dec_state_t       st_next,
    output logic [2:0][7:0]           chars,
    output logic [1:0]                count
);

    logic [7:0] b;
    logic [4:0] hv;
    logic       dropped;

    assign b  = item.in_byte;
    assign hv = pec_pkg::hex_value(b);

    always_comb begin
        st_next = st;
        chars   = '0;
        count   = 2'd0;
        dropped = 1'b0;
        if (direction == pec_pkg::DIR_ENCODE) begin
            if (b > pec_pkg::CH_SPACE && b <= pec_pkg::CH_TILDE &&
                b != pec_pkg::CH_EQUAL && b != pec_pkg::CH_QUOTE &&
                b != pec_pkg::CH_AMP && b != pec_pkg::CH_PERCENT &&
                b != pec_pkg::CH_PLUS) begin
                chars[0] = b;
                count    = 2'd1;
            end else if (b == pec_pkg::CH_SPACE) begin
                chars[0] = pec_pkg::CH_PLUS;
                count    = 2'd1;
            end else begin
                chars[0] = pec_pkg::CH_PERCENT;
                chars[1] = pec_pkg::hex_char(b[7:4]);
                chars[2] = pec_pkg::hex_char(b[3:0]);
                count    = 2'd3;
            end
        end else if (!st.string_ended) begin
            if (b == pec_pkg::CH_NUL) begin
                st_next.string_ended = 1'b1;
                st_next.escape_phase = pec_pkg::PHASE_NONE;
                st_next.hex_partial  = 4'd0;
                st_next.hex_stopped  = 1'b0;
                st_next.just_toggled = 1'b0;
            end else if (st.escape_phase == pec_pkg::PHASE_FIRST) begin
                if (b == pec_pkg::CH_PERCENT) begin
                    st_next.escape_phase = pec_pkg::PHASE_NONE;
                    chars[0] = pec_pkg::CH_PERCENT;
                    count    = 2'd1;
                end else begin
                    st_next.hex_partial  = hv[4] ? hv[3:0] : 4'd0;
                    st_next.hex_stopped  = !hv[4];
                    st_next.escape_phase = pec_pkg::PHASE_SECOND;
                end
            end else if (st.escape_phase == pec_pkg::PHASE_SECOND) begin
                if (!st.hex_stopped && hv[4]) begin
                    chars[0] = {st.hex_partial, hv[3:0]};
                end else begin
                    chars[0] = {4'h0, st.hex_partial};
                end
                count = 2'd1;
                st_next.escape_phase = pec_pkg::PHASE_NONE;
                st_next.hex_partial  = 4'd0;
                st_next.hex_stopped  = 1'b0;
            end else begin
                if (st.just_toggled) begin
                    st_next.just_toggled = 1'b0;
                end else if (b == pec_pkg::CH_QUOTE) begin
                    st_next.quote_mode   = !st.quote_mode;
                    st_next.just_toggled = 1'b1;
                    dropped = 1'b1;
                end
                if (!dropped) begin
                    if (!st.quote_mode && b == pec_pkg::CH_PLUS) begin
                        chars[0] = pec_pkg::CH_SPACE;
                        count    = 2'd1;
                    end else if (!st.quote_mode && b == pec_pkg::CH_PERCENT) begin
                        st_next.escape_phase = pec_pkg::PHASE_FIRST;
                    end else begin
                        chars[0] = b;
                        count    = 2'd1;
                    end
                end
            end
        end
        // string boundary clears the decoder in either direction
        if (item.in_last) begin
            st_next = '0;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/percent_escape_codec.sv -----
`timescale 1ns / 1ps
`default_nettype none
// the accept edge loads the input register; the codec result of the item is loaded
//   into the result buffer once the buffer is free, unless the item gives nothing
// the result buffer sends one result per cycle while m_ready is high, and takes a
//   new item only when it is empty or its last character is being taken
// reset: synchronous active-low aresetn empties both stages, direction = encode
//   and clears the decoder state
// ----------------------------------------------------------------------------
// percent_escape_codec: percent / plus escape encoder and decoder
// encode: byte to one or three characters, decode: text to bytes with quotes
// ----------------------------------------------------------------------------
module percent_escape_codec (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // direction register write channel
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data,
    // input items
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire pec_pkg::in_item_t   s_payload,
    // result items
    output logic                     m_valid,
    input  wire logic                m_ready,
    output pec_pkg::out_item_t       m_payload
);

    // direction register
    logic direction_reg;

    // input register stage
    logic               in_valid_reg;
    pec_pkg::in_item_t  in_item_reg;

    // decoder state
    pec_pkg::dec_state_t state_reg;
    pec_pkg::dec_state_t state_next;

    // result buffer: up to three characters, sent one a cycle while m_ready is high
    logic             buf_valid_reg;
    logic [2:0][7:0]  buf_chars_reg;
    logic [1:0]       buf_cnt_reg;
    logic [1:0]       buf_ptr_reg;

    logic [2:0][7:0]  chars;
    logic [1:0]       count;
    logic             buf_last;
    logic             buf_free;
    logic             consume;

    pec_codec u_codec (
        .direction (direction_reg),
        .item      (in_item_reg),
        .st        (state_reg),
        .st_next   (state_next),
        .chars     (chars),
        .count     (count)
    );

    // the last character of the buffered item
    assign buf_last = (buf_ptr_reg == (buf_cnt_reg - 2'd1));
    // buffer can take a new item this cycle
    assign buf_free = !buf_valid_reg || (m_ready && buf_last);
    // an item that gives nothing leaves without waiting for the buffer
    assign consume  = in_valid_reg && ((count == 2'd0) || buf_free);

    assign s_ready   = !in_valid_reg || consume;
    assign cfg_ready = 1'b1;

    assign m_valid            = buf_valid_reg;
    assign m_payload.out_byte = buf_chars_reg[buf_ptr_reg];
    assign m_payload.run_last = buf_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= pec_pkg::DIR_ENCODE;
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            buf_valid_reg <= 1'b0;
            buf_cnt_reg   <= 2'd0;
            buf_ptr_reg   <= 2'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                direction_reg <= cfg_data;
            end

            // input stage
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end

            if (consume) begin
                state_reg <= state_next;
            end

            // result buffer
            if (consume && count != 2'd0) begin
                buf_valid_reg <= 1'b1;
                buf_cnt_reg   <= count;
                buf_ptr_reg   <= 2'd0;
            end else if (buf_valid_reg && m_ready) begin
                if (buf_last) begin
                    buf_valid_reg <= 1'b0;
                end else begin
                    buf_ptr_reg <= buf_ptr_reg + 2'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_payload;
        end
        if (consume && count != 2'd0) begin
            buf_chars_reg <= chars;
        end
    end

    // the send pointer never runs past the buffered count
    a_ptr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_valid_reg |-> (buf_cnt_reg != 2'd0 && buf_ptr_reg < buf_cnt_reg))
        else $error("result pointer out of range");

    // a three-character result is always a percent escape
    a_escape_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (buf_valid_reg && buf_cnt_reg == 2'd3 && buf_ptr_reg == 2'd0)
        |-> (m_payload.out_byte == pec_pkg::CH_PERCENT))
        else $error("three-character result without escape mark");

    // a string end clears all decoder state
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && in_item_reg.in_last) |=> (state_reg == '0))
        else $error("decoder state not cleared after string end");

    // encoding never touches the decoder state unless the string ends
    a_encode_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && direction_reg == pec_pkg::DIR_ENCODE && !in_item_reg.in_last)
        |=> $stable(state_reg))
        else $error("encoder changed decoder state");

    // an empty input stage always takes an item
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

endmodule
`default_nettype wire
